FILE: src/gfie_pkg.sv
`timescale 1ns / 1ps
// Package for the GF(2^m) extended Euclidean inverter.
// Widths, register map, controller states and command/status structs; no dependencies.
package gfie_pkg;

    localparam int DEGREE  = 8;
    localparam int DW      = DEGREE + 1;
    localparam int SW      = $clog2(DW);
    localparam int TDATA_W = ((DEGREE + 7) / 8) * 8;
    localparam int AW      = 3;

    localparam logic [DW-1:0]   MOD_TOP   = DW'(1) << DEGREE;
    localparam logic [DW-1:0]   MOD_RESET = DW'(283);
    localparam logic [AW-3:0]   REG_MODULUS = '0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_NEXT,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic setup;
        logic step;
        logic rotate;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic u_one;
        logic u_zero;
        logic s_zero;
    } t_stat;

    // degree of a polynomial; zero polynomial gives 0
    function automatic logic [SW-1:0] poly_deg(input logic [DW-1:0] a);
        logic [SW-1:0] d;
        d = '0;
        for (int i = 0; i < DW; i++) begin
            if (a[i]) d = SW'(i);
        end
        return d;
    endfunction

endpackage

FILE: src/gfie_ctrl.sv
`timescale 1ns / 1ps
// Controller FSM of the GF(2^m) inverter.
// Depends on gfie_pkg; drives commands to gfie_dp from its status.
module gfie_ctrl import gfie_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_out_free,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (i_stat.u_one || i_stat.u_zero) n_state = ST_FINISH;
                else n_state = ST_DIV;
            end
            ST_DIV: begin
                if (i_stat.s_zero) n_state = ST_NEXT;
            end
            ST_NEXT: begin
                n_state = ST_CHECK;
            end
            ST_FINISH: begin
                if (i_out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_CHECK: begin
                o_cmd.setup = !(i_stat.u_one || i_stat.u_zero);
            end
            ST_DIV: begin
                o_cmd.step = 1'b1;
            end
            ST_NEXT: begin
                o_cmd.rotate = 1'b1;
            end
            ST_FINISH: begin
                o_cmd.finish = i_out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

FILE: src/gfie_dp.sv
`timescale 1ns / 1ps
// Datapath of the GF(2^m) inverter: remainder pair, cofactor pair,
// bit-serial division with interleaved cofactor multiply-reduce. Depends on gfie_pkg.
module gfie_dp import gfie_pkg::*; (
    input  logic              i_clk,
    input  t_cmd              i_cmd,
    input  logic [DEGREE-1:0] i_operand,
    input  logic [DW-1:0]     i_modulus,
    output t_stat             o_stat,
    output logic [DEGREE-1:0] o_x1
);

    logic [DW-1:0]     r_u, r_v, r_r;
    logic [DEGREE-1:0] r_x1, r_x2, r_acc;
    logic [SW-1:0]     r_du, r_s;

    logic [SW-1:0]     w_idx;
    logic              w_qbit;
    logic [DW-1:0]     w_acc_sh;
    logic [DW-1:0]     w_acc_red;
    logic [DEGREE-1:0] n_acc;
    logic [DW-1:0]     n_r;

    assign w_idx     = r_du + r_s;
    assign w_qbit    = r_r[w_idx];
    assign n_r       = w_qbit ? (r_r ^ (r_u << r_s)) : r_r;
    assign w_acc_sh  = {r_acc, 1'b0};
    assign w_acc_red = w_acc_sh[DEGREE] ? (w_acc_sh ^ i_modulus) : w_acc_sh;
    assign n_acc     = w_acc_red[DEGREE-1:0] ^ (w_qbit ? r_x1 : '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_u  <= {1'b0, i_operand};
            r_v  <= i_modulus;
            r_x1 <= DEGREE'(1);
            r_x2 <= '0;
        end
        if (i_cmd.setup) begin
            r_r   <= r_v;
            r_acc <= '0;
            r_du  <= poly_deg(r_u);
            r_s   <= poly_deg(r_v) - poly_deg(r_u);
        end
        if (i_cmd.step) begin
            r_r   <= n_r;
            r_acc <= n_acc;
            r_s   <= r_s - SW'(1);
        end
        if (i_cmd.rotate) begin
            r_v  <= r_u;
            r_u  <= r_r;
            r_x2 <= r_x1;
            r_x1 <= r_x2 ^ r_acc;
        end
    end

    assign o_stat.u_one  = (r_u == DW'(1));
    assign o_stat.u_zero = (r_u == '0);
    assign o_stat.s_zero = (r_s == '0);
    assign o_x1          = r_x1;

endmodule

FILE: src/gf2m_inverse_ext_euclid.sv
`timescale 1ns / 1ps
// Top level: GF(2^m) inverse by extended Euclid, stream in/out, APB modulus register.
// Flow: the input transfer loads gfie_dp, then each Euclid round runs CHECK, the division loop
// in gfie_dp (one quotient bit per cycle) and NEXT, until FINISH loads the output register.
// Items are taken one at a time; the next transfer is taken only after the result is
// loaded into the output register, and FINISH waits while the output register is stalled.
// Reset (synchronous, active low): controller idle, output empty, modulus back to 0x11B.
module gf2m_inverse_ext_euclid import gfie_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [TDATA_W-1:0] i_s_axis_tdata,   // [DEGREE-1:0] operand
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [TDATA_W-1:0] o_m_axis_tdata,   // [DEGREE-1:0] inverse
    output logic [0:0]         o_m_axis_tuser,   // [0] status
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [AW-1:0]      paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [DW-1:0]     r_modulus;
    logic              r_out_valid;
    logic [DEGREE-1:0] r_inverse;
    logic              r_status;

    logic              w_hit;
    logic              w_out_free;
    logic [DW-1:0]     w_modulus;
    logic [DEGREE-1:0] w_x1;
    t_cmd              w_cmd;
    t_stat             w_stat;

    assign pready = 1'b1;
    assign w_hit  = (paddr[AW-1:2] == REG_MODULUS);
    assign prdata = w_hit ? 32'(r_modulus) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MOD_RESET;
        end else if (psel && penable && pwrite && pready && w_hit) begin
            r_modulus <= pwdata[DW-1:0];
        end
    end

    assign w_modulus  = r_modulus | MOD_TOP;
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    gfie_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_out_free (w_out_free),
        .i_stat     (w_stat),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (w_cmd)
    );

    gfie_dp u_dp (
        .i_clk     (i_clk),
        .i_cmd     (w_cmd),
        .i_operand (i_s_axis_tdata[DEGREE-1:0]),
        .i_modulus (w_modulus),
        .o_stat    (w_stat),
        .o_x1      (w_x1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.finish) begin
            r_inverse <= w_stat.u_zero ? '0 : w_x1;
            r_status  <= w_stat.u_zero;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = TDATA_W'(r_inverse);
    assign o_m_axis_tuser[0] = r_status;

endmodule

FILE: src/gfie_chk.sv
`timescale 1ns / 1ps
// Port-level checker for gf2m_inverse_ext_euclid, bound to the top level.
// Depends on gfie_pkg.
module gfie_chk import gfie_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_s_axis_tvalid,
    input logic               o_s_axis_tready,
    input logic [TDATA_W-1:0] i_s_axis_tdata,
    input logic               o_m_axis_tvalid,
    input logic               i_m_axis_tready,
    input logic [TDATA_W-1:0] o_m_axis_tdata,
    input logic [0:0]         o_m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled output transfer changed");

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input taken while busy");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tdata == '0)
        else $error("failed inverse not zero");

    a_ok_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |-> o_m_axis_tdata != '0)
        else $error("found inverse is zero");

endmodule

bind gf2m_inverse_ext_euclid gfie_chk u_gfie_chk (.*);

FILE: verif/gfie_checker.sv
`timescale 1ns / 1ps
// Checker for gf2m_inverse_ext_euclid: watches the operand/result streams and the APB port,
// keeps its own modulus copy, predicts each inverse and compares. Depends on gfie_pkg.
module gfie_checker import gfie_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    input  logic               i_s_tready,
    input  logic [TDATA_W-1:0] i_s_tdata,   // [DEGREE-1:0] operand
    input  logic               i_m_tvalid,
    input  logic               i_m_tready,
    input  logic [TDATA_W-1:0] i_m_tdata,   // [DEGREE-1:0] inverse
    input  logic [0:0]         i_m_tuser,   // [0] status
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [AW-1:0]      i_paddr,
    input  logic [31:0]        i_pwdata,
    input  logic [31:0]        i_prdata,
    input  logic               i_pready,
    output int                 o_outstanding,
    output int                 o_errors
);

    typedef struct packed {
        logic [DEGREE-1:0] inverse;
        logic              status;
    } t_inverse;

    t_inverse      inverse_q[$];
    logic [DW-1:0] modulus;

    function automatic int top_bit(input logic [DW-1:0] p);
        int d;
        d = -1;
        for (int i = 0; i < DW; i++) begin
            if (p[i]) d = i;
        end
        return d;
    endfunction

    // (a * b) mod m, carry-less; m monic of degree DEGREE
    function automatic logic [DEGREE-1:0] clmul_mod(input logic [DW-1:0] a,
                                                    input logic [DEGREE-1:0] b,
                                                    input logic [DW-1:0] m);
        logic [DW-1:0] acc;
        acc = '0;
        for (int i = DEGREE; i >= 0; i--) begin
            acc = acc << 1;
            if (acc[DEGREE]) acc = acc ^ m;
            if (a[i]) acc = acc ^ DW'(b);
        end
        return acc[DEGREE-1:0];
    endfunction

    function automatic t_inverse gf_invert(input logic [DEGREE-1:0] op,
                                           input logic [DW-1:0] mod_reg);
        logic [DW-1:0]     m, u, v, r, q;
        logic [DEGREE-1:0] x1, x2, x;
        int                du;
        t_inverse          res;
        m = mod_reg | MOD_TOP;
        u = DW'(op);
        v = m;
        x1 = DEGREE'(1);
        x2 = '0;
        res.status = 1'b0;
        while (u != DW'(1) && !res.status) begin
            if (u == '0) begin
                res.status = 1'b1;
            end else begin
                du = top_bit(u);
                r = v;
                q = '0;
                for (int s = top_bit(v) - du; s >= 0; s--) begin
                    if (r[du + s]) begin
                        r = r ^ (u << s);
                        q[s] = 1'b1;
                    end
                end
                x = x2 ^ clmul_mod(q, x1, m);
                v = u;
                u = r;
                x2 = x1;
                x1 = x;
            end
        end
        res.inverse = res.status ? '0 : x1;
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_inverse want;
        int       fails;
        if (!i_rst_n) begin
            modulus = MOD_RESET;
            inverse_q.delete();
            o_outstanding <= 0;
            o_errors <= 0;
        end else begin
            fails = 0;
            if (i_psel && i_penable && i_pready && i_paddr[AW-1:2] == REG_MODULUS) begin
                if (i_pwrite) begin
                    modulus = i_pwdata[DW-1:0];
                end else if (i_prdata !== 32'(modulus)) begin
                    $error("modulus_poly readback expected %0h actual %0h", modulus, i_prdata);
                    fails++;
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                if (inverse_q.size() == 0) begin
                    $error("result transfer with nothing expected: inverse %0h status %0b",
                           i_m_tdata[DEGREE-1:0], i_m_tuser[0]);
                    fails++;
                end else begin
                    want = inverse_q.pop_front();
                    if (i_m_tdata[DEGREE-1:0] !== want.inverse) begin
                        $error("inverse expected %0h actual %0h",
                               want.inverse, i_m_tdata[DEGREE-1:0]);
                        fails++;
                    end
                    if (i_m_tuser[0] !== want.status) begin
                        $error("status expected %0b actual %0b", want.status, i_m_tuser[0]);
                        fails++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                inverse_q.push_back(gf_invert(i_s_tdata[DEGREE-1:0], modulus));
            end
            o_outstanding <= inverse_q.size();
            o_errors <= o_errors + fails;
        end
    end

endmodule

FILE: verif/tb_gf2m_inverse_ext_euclid.sv
`timescale 1ns / 1ps
// Testbench top for gf2m_inverse_ext_euclid: clock, reset, operand stream, result back-pressure,
// modulus reconfiguration over APB and the verdict. Depends on gfie_pkg and gfie_checker.
module tb_gf2m_inverse_ext_euclid import gfie_pkg::*; ();

    localparam logic [AW-1:0] ADDR_MODULUS = {REG_MODULUS, 2'b00};
    localparam logic [AW-1:0] ADDR_SPARE   = ADDR_MODULUS + AW'(4);
    localparam int            PHASES       = 8;
    localparam int            PHASE_ITEMS  = 141;
    localparam int            SETTLE       = 60;
    localparam int            CYCLE_LIMIT  = 600000;
    localparam logic [31:0]   PHASE_MOD [PHASES] = '{
        32'h11B, 32'h11D, 32'h100, 32'h1FF, 32'h0C3, 32'h187, 32'h0, 32'h0
    };

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_s_axis_tvalid = 1'b0;
    logic               o_s_axis_tready;
    logic [TDATA_W-1:0] i_s_axis_tdata = '0;   // [DEGREE-1:0] operand
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] o_m_axis_tdata;        // [DEGREE-1:0] inverse
    logic [0:0]         o_m_axis_tuser;        // [0] status
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [AW-1:0]      paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    int   outstanding;
    int   error_count;
    int   cycle_count = 0;
    logic calm = 1'b0;

    gf2m_inverse_ext_euclid i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    gfie_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_axis_tvalid),
        .i_s_tready    (o_s_axis_tready),
        .i_s_tdata     (i_s_axis_tdata),
        .i_m_tvalid    (o_m_axis_tvalid),
        .i_m_tready    (i_m_axis_tready),
        .i_m_tdata     (o_m_axis_tdata),
        .i_m_tuser     (o_m_axis_tuser),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_prdata      (prdata),
        .i_pready      (pready),
        .o_outstanding (outstanding),
        .o_errors      (error_count)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_m_axis_tready <= calm || ($urandom_range(0, 99) >= 36);
    end

    // valid stays high across back-to-back transfers; dropped only for an idle gap
    task automatic send_operand(input logic [DEGREE-1:0] op);
        if (!calm && $urandom_range(0, 99) < 36) begin
            i_s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < 36);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= TDATA_W'(op);
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic wait_drained(input int settle);
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic write, input logic [AW-1:0] addr,
                              input logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_modulus(input logic [AW-1:0] addr, input logic [31:0] word);
        wait_drained(SETTLE);
        apb_access(1'b1, addr, word);
        apb_access(1'b0, ADDR_MODULUS, '0);
    endtask

    initial begin : stimulus
        logic [DEGREE-1:0] op;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        apb_access(1'b0, ADDR_MODULUS, '0);

        // reset modulus x^8+x^4+x^3+x+1: zero, one, extremes, a known pair
        send_operand(8'h00); send_operand(8'h01); send_operand(8'h02); send_operand(8'h80);
        send_operand(8'hFF); send_operand(8'h53); send_operand(8'hCA); send_operand(8'hAA);
        send_operand(8'h55); send_operand(8'h7F);

        // write to an unmapped index must not disturb the modulus
        set_modulus(ADDR_SPARE, 32'hFFFF_FFFF);
        send_operand(8'h53);

        // modulus x^8: even operands share a factor
        set_modulus(ADDR_MODULUS, 32'h100);
        send_operand(8'h02); send_operand(8'h03); send_operand(8'h81); send_operand(8'h00);

        // top bit clear is treated as set
        set_modulus(ADDR_MODULUS, 32'h01B);
        send_operand(8'h53); send_operand(8'h01);

        set_modulus(ADDR_MODULUS, 32'h1FF);
        send_operand(8'hFF); send_operand(8'h03); send_operand(8'h80);

        for (int ph = 0; ph < PHASES; ph++) begin
            set_modulus(ADDR_MODULUS, (PHASE_MOD[ph] == '0) ? $urandom : PHASE_MOD[ph]);
            calm = (ph == 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 19) == 0) begin
                    case ($urandom_range(0, 2))
                        0: op = '0;
                        1: op = DEGREE'(1);
                        default: op = '1;
                    endcase
                end else begin
                    op = DEGREE'($urandom_range(0, 255));
                end
                send_operand(op);
                if (n % 47 == 46) wait_drained(0);
            end
        end
        calm = 1'b0;

        wait_drained(SETTLE);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

endmodule
